### hw/rtl/tcw_pkg.sv
// shared constants and types of the text console writer
`timescale 1ns / 1ps

package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;

   // field widths fixed by the command and response beats
   localparam int ADDR_W = 11;
   localparam int CHAR_W = 8;
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;

   localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0a;
   localparam logic [CHAR_W-1:0] NULL_CODE    = 8'h00;

   localparam logic CMD_PUT  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // write request and clear request from the cursor logic
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CHAR_W-1:0] wr_data;
      logic              clear;
   } put_type;

endpackage

### hw/rtl/tcw_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module tcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/tcw_cursor.sv
// cursor registers and put command handling
`timescale 1ns / 1ps

module tcw_cursor (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic                      cmd,
   input  logic [tcw_pkg::CHAR_W-1:0] char_code,
   output tcw_pkg::put_type          put,
   output logic [tcw_pkg::COL_W-1:0] col,
   output logic [tcw_pkg::ROW_W-1:0] row
);

   logic [tcw_pkg::COL_W-1:0] col_ff, col_in;
   logic [tcw_pkg::ROW_W-1:0] row_ff, row_in;
   logic                      next_row;

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      next_row    = 1'b0;
      put.wr_en   = 1'b0;
      put.clear   = 1'b0;
      put.wr_data = char_code;
      // cell index row * columns + column
      put.wr_addr = tcw_pkg::ADDR_W'(32'(row_ff) * 32'(tcw_pkg::COLUMNS) + 32'(col_ff));
      if (accept && cmd == tcw_pkg::CMD_PUT && char_code != tcw_pkg::NULL_CODE) begin
         if (char_code == tcw_pkg::NEWLINE_CODE) begin
            col_in   = '0;
            next_row = 1'b1;
         end else begin
            put.wr_en = 1'b1;
            if (col_ff == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1)) begin
               col_in   = '0;
               next_row = 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         if (next_row) begin
            // off the bottom: wipe the screen and home the cursor
            if (row_ff == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) begin
               put.clear = 1'b1;
               row_in    = '0;
               col_in    = '0;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign col = col_ff;
   assign row = row_ff;

endmodule

### hw/rtl/text_console_writer_top.sv
// text console writer top level: character store, clear sweep and response beat
// a response beat appears in the cycle after each accepted command
// throughput: one command per cycle while busy is low, puts and reads alike
// a put that runs off the bottom row starts a clear sweep of all 2000 cells
// (one cell per cycle through the store write port), busy stays high meanwhile
// reset homes the cursor and runs the same sweep to fill every cell with spaces
`timescale 1ns / 1ps

module text_console_writer_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_cmd,
   input  logic [tcw_pkg::CHAR_W-1:0] req_char_code,
   input  logic [tcw_pkg::ADDR_W-1:0] req_read_address,
   output logic                       rsp_valid,
   output logic [tcw_pkg::CHAR_W-1:0] rsp_read_char,
   output logic [tcw_pkg::COL_W-1:0]  rsp_cursor_column,
   output logic [tcw_pkg::ROW_W-1:0]  rsp_cursor_row,
   output logic                       rsp_screen_cleared
);

   logic                       accept;
   tcw_pkg::put_type           put;
   logic [tcw_pkg::COL_W-1:0]  col;
   logic [tcw_pkg::ROW_W-1:0]  row;

   logic                       clearing_ff, clearing_in;
   logic [tcw_pkg::ADDR_W-1:0] sweep_ff, sweep_in;
   logic                       rsp_valid_ff;
   logic                       rd_hit_ff;
   logic                       cleared_ff;
   logic                       rd_en;

   logic                       ram_we;
   logic [tcw_pkg::ADDR_W-1:0] ram_waddr;
   logic [tcw_pkg::CHAR_W-1:0] ram_wdata;
   logic [tcw_pkg::CHAR_W-1:0] ram_rdata;

   assign busy   = clearing_ff;
   assign accept = start && !clearing_ff;
   assign rd_en  = accept && req_cmd == tcw_pkg::CMD_READ
                   && 32'(req_read_address) < 32'(tcw_pkg::CELLS);

   tcw_cursor u_cursor (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .cmd       (req_cmd),
      .char_code (req_char_code),
      .put       (put),
      .col       (col),
      .row       (row)
   );

   // sweep owns the write port; no command is taken while it runs
   always_comb begin
      ram_we    = clearing_ff || put.wr_en;
      ram_waddr = clearing_ff ? sweep_ff : put.wr_addr;
      ram_wdata = clearing_ff ? tcw_pkg::SPACE_CODE : put.wr_data;
   end

   tcw_ram #(
      .WIDTH  (tcw_pkg::CHAR_W),
      .DEPTH  (tcw_pkg::CELLS),
      .ADDR_W (tcw_pkg::ADDR_W)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (rd_en),
      .raddr (req_read_address),
      .rdata (ram_rdata)
   );

   always_comb begin
      clearing_in = clearing_ff;
      sweep_in    = sweep_ff;
      if (clearing_ff) begin
         if (sweep_ff == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1)) begin
            clearing_in = 1'b0;
         end
         sweep_in = sweep_ff + 1'b1;
      end else if (put.clear) begin
         clearing_in = 1'b1;
         sweep_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_hit_ff  <= rd_en;
         cleared_ff <= put.clear;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_char      = rd_hit_ff ? ram_rdata : tcw_pkg::NULL_CODE;
   assign rsp_cursor_column  = col;
   assign rsp_cursor_row     = row;
   assign rsp_screen_cleared = rsp_valid_ff && cleared_ff;

`ifndef NO_ASSERTIONS
   a_beat_follows_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("accepted command gave no response beat");

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_cursor_column) < 32'(tcw_pkg::COLUMNS)
                     && 32'(rsp_cursor_row) < 32'(tcw_pkg::ROWS)))
      else $error("cursor outside the screen");

   a_clear_homes: assert property (@(posedge clock) disable iff (reset)
      rsp_screen_cleared |-> (busy && rsp_cursor_column == '0 && rsp_cursor_row == '0))
      else $error("screen clear without home cursor and sweep");

   a_sweep_done: assert property (@(posedge clock) disable iff (reset)
      (clearing_ff && sweep_ff == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1)) |=> !busy)
      else $error("sweep did not end after the last cell");
`endif

endmodule
